>>> sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger: register map,
// payload structs, measurement phases and controller/datapath handshake.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Field widths
  localparam int TIMER_BITS_DEF = 17;
  localparam int MAX_SAMPLES    = 15;
  localparam int DIST_W         = 18;
  localparam int SUM_W          = 22;
  localparam int CNT_W          = 4;
  localparam int TRIG_W         = 8;
  localparam int LIM_W          = 17;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 18;

  // Distance scaling: ticks * 1124 >> 8 gives 1/256 cm
  localparam int DIST_MULT   = 1124;
  localparam int DIST_MULT_W = 11;
  localparam int DIST_SHIFT  = 8;

  // Register reset values
  localparam logic [TRIG_W-1:0] TRIGGER_RST = 8'd10;
  localparam logic [LIM_W-1:0]  TIMEOUT_RST = 17'd30000;
  localparam logic [LIM_W-1:0]  GAP_RST     = 17'd60000;
  localparam logic [CNT_W-1:0]  SAMPLES_RST = 4'd3;
  localparam logic [DIST_W-1:0] MIN_RST     = 18'd512;
  localparam logic [DIST_W-1:0] MAX_RST     = 18'd102400;

  // Register map
  typedef enum logic [CFG_AW-1:0] {
    REG_TRIGGER = 3'd0,
    REG_TIMEOUT = 3'd1,
    REG_GAP     = 3'd2,
    REG_SAMPLES = 3'd3,
    REG_MIN     = 3'd4,
    REG_MAX     = 3'd5
  } cfg_reg_t;

  // Measurement phase
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_RISE = 5'b00100,
    PH_MEAS = 5'b01000,
    PH_GAP  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              start_req;
    logic              echo_level;
    logic [DIST_W-1:0] range_low;
    logic [DIST_W-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic              average_valid;
    logic [DIST_W-1:0] average_distance;
    logic [CNT_W-1:0]  valid_readings;
    logic              in_range;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic fin;
    logic div_start;
    logic avg;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_fin;
    logic gap_end;
    logic div_done;
  } dp_stat_t;

endpackage

>>> sv/uer_div.sv
// ----------------------------------------------------------------------------
// uer_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uer_div #(
  parameter int NW  = uer_pkg::SUM_W,
  parameter int DVW = uer_pkg::CNT_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [DVW:0]   rem_r, rem_nxt;
  logic [NW-1:0]  quo_r, quo_nxt;
  logic [DVW-1:0] dvs_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DVW:0]   shifted;
  logic           qbit;

  // one restoring step
  always_comb begin
    shifted  = {rem_r[DVW-1:0], quo_r[NW-1]};
    qbit     = (shifted >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_nxt = {quo_r[NW-2:0], qbit};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> sv/uer_dp.sv
// ----------------------------------------------------------------------------
// uer_dp
// Ranger datapath: configuration registers, phase and tick timers, distance
// multiplier, limit checks, accumulation, serial averaging and result register.
// ----------------------------------------------------------------------------
module uer_dp #(
  parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [uer_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [uer_pkg::CFG_DW-1:0] cfg_wdata,
  input  uer_pkg::in_item_t          in_data,
  input  uer_pkg::dp_cmd_t           cmd,
  output uer_pkg::dp_stat_t          stat,
  output uer_pkg::out_item_t         out_data
);
  import uer_pkg::*;

  localparam int TB = TIMER_BITS;
  localparam int PW = TB + DIST_MULT_W;
  localparam int DW = PW - DIST_SHIFT;
  localparam logic [TB-1:0] TMASK = '1;

  // clamp a limit register to the timer range
  function automatic logic [TB-1:0] lim(input logic [LIM_W-1:0] v);
    logic [TB-1:0] r;
    if (32'(v) > 32'(TMASK)) r = TMASK;
    else                     r = TB'(v);
    return r;
  endfunction

  // configuration
  logic [TRIG_W-1:0] trig_cfg_r;
  logic [LIM_W-1:0]  tmo_cfg_r, gap_cfg_r;
  logic [CNT_W-1:0]  samp_cfg_r;
  logic [DIST_W-1:0] min_cfg_r, max_cfg_r;

  // measurement state
  phase_t            phase_r, phase_nxt;
  logic [TB-1:0]     timer_r, timer_nxt;
  logic [TB-1:0]     width_r, width_nxt;
  logic [CNT_W-1:0]  readings_r, readings_nxt;
  logic [CNT_W-1:0]  vcount_r, vcount_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DIST_W-1:0] blo_r, blo_nxt, bhi_r, bhi_nxt;
  logic [DIST_W-1:0] avg_r, avg_nxt;
  logic [1:0]        flags_r, flags_nxt;
  logic              done_r, done_nxt;

  in_item_t          item_r;
  out_item_t         out_r;
  logic [PW-1:0]     prod_r;

  logic [TB-1:0]     tmo, gap_lim, gap_tick;
  logic [CNT_W-1:0]  wanted;
  logic [DW-1:0]     dist_val;
  logic              dist_ok;
  logic              gap_end, need_fin;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic [DIST_W-1:0] avg_val;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_cfg_r <= TRIGGER_RST;
      tmo_cfg_r  <= TIMEOUT_RST;
      gap_cfg_r  <= GAP_RST;
      samp_cfg_r <= SAMPLES_RST;
      min_cfg_r  <= MIN_RST;
      max_cfg_r  <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TRIGGER: trig_cfg_r <= cfg_wdata[TRIG_W-1:0];
        REG_TIMEOUT: tmo_cfg_r  <= cfg_wdata[LIM_W-1:0];
        REG_GAP:     gap_cfg_r  <= cfg_wdata[LIM_W-1:0];
        REG_SAMPLES: samp_cfg_r <= cfg_wdata[CNT_W-1:0];
        REG_MIN:     min_cfg_r  <= cfg_wdata[DIST_W-1:0];
        REG_MAX:     max_cfg_r  <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch and distance product (registered before the limit check)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    prod_r <= PW'(width_r) * PW'(DIST_MULT);
  end

  // derived limits and conditions
  always_comb begin
    tmo      = lim(tmo_cfg_r);
    gap_lim  = lim(gap_cfg_r);
    gap_tick = (timer_r != TMASK) ? timer_r + TB'(1) : timer_r;
    wanted   = (samp_cfg_r == '0) ? CNT_W'(1) : samp_cfg_r;
    if (32'(wanted) > MAX_SAMPLES) begin
      wanted = CNT_W'(MAX_SAMPLES);
    end
    gap_end  = (phase_r == PH_GAP) && (gap_tick >= gap_lim) && (readings_r >= wanted);
    need_fin = (phase_r == PH_MEAS) && !item_r.echo_level;
    dist_val = prod_r[PW-1:DIST_SHIFT];
    dist_ok  = (dist_val != '0) && (32'(dist_val) >= 32'(min_cfg_r)) &&
               (32'(dist_val) <= 32'(max_cfg_r));
    avg_val  = (vcount_r != '0) ? quotient[DIST_W-1:0] : '0;
  end

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    width_nxt    = width_r;
    readings_nxt = readings_r;
    vcount_nxt   = vcount_r;
    sum_nxt      = sum_r;
    blo_nxt      = blo_r;
    bhi_nxt      = bhi_r;
    avg_nxt      = avg_r;
    flags_nxt    = flags_r;
    done_nxt     = cmd.load ? 1'b0 : done_r;

    // one tick of the phase sequence
    if (cmd.step) begin
      case (phase_r)
        PH_TRIG: begin
          if (32'(timer_r) >= 32'(trig_cfg_r)) begin
            phase_nxt = PH_RISE;
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_r + TB'(1);
          end
        end
        PH_RISE: begin
          if (item_r.echo_level) begin
            phase_nxt = PH_MEAS;
            width_nxt = '0;
          end else if (timer_r >= tmo) begin
            readings_nxt = readings_r + CNT_W'(1);
            phase_nxt    = PH_GAP;
            timer_nxt    = '0;
          end else begin
            timer_nxt = timer_r + TB'(1);
          end
        end
        PH_MEAS: begin
          // echo fall is finished by the fin command
          if (item_r.echo_level) begin
            if (width_r >= tmo) begin
              readings_nxt = readings_r + CNT_W'(1);
              phase_nxt    = PH_GAP;
              timer_nxt    = '0;
            end else begin
              width_nxt = width_r + TB'(1);
            end
          end
        end
        PH_GAP: begin
          // end of measurement is finished by the avg command
          if (!gap_end) begin
            if (gap_tick >= gap_lim) begin
              phase_nxt = PH_TRIG;
              timer_nxt = TB'(1);
            end else begin
              timer_nxt = gap_tick;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (item_r.start_req) begin
            blo_nxt      = item_r.range_low;
            bhi_nxt      = item_r.range_high;
            readings_nxt = '0;
            vcount_nxt   = '0;
            sum_nxt      = '0;
            width_nxt    = '0;
            phase_nxt    = PH_TRIG;
            timer_nxt    = TB'(1);
          end
        end
      endcase
    end

    // completed echo: check limits and accumulate
    if (cmd.fin) begin
      if (dist_ok) begin
        vcount_nxt = vcount_r + CNT_W'(1);
        sum_nxt    = sum_r + SUM_W'(dist_val);
      end
      readings_nxt = readings_r + CNT_W'(1);
      phase_nxt    = PH_GAP;
      timer_nxt    = '0;
    end

    // measurement complete: publish the average
    if (cmd.avg) begin
      avg_nxt      = avg_val;
      flags_nxt[0] = (vcount_r != '0);
      flags_nxt[1] = (vcount_r != '0) && (avg_val >= blo_r) && (avg_val <= bhi_r);
      phase_nxt    = PH_IDLE;
      timer_nxt    = '0;
      done_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      timer_r    <= '0;
      width_r    <= '0;
      readings_r <= '0;
      vcount_r   <= '0;
      sum_r      <= '0;
      blo_r      <= '0;
      bhi_r      <= '0;
      avg_r      <= '0;
      flags_r    <= '0;
      done_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      timer_r    <= timer_nxt;
      width_r    <= width_nxt;
      readings_r <= readings_nxt;
      vcount_r   <= vcount_nxt;
      sum_r      <= sum_nxt;
      blo_r      <= blo_nxt;
      bhi_r      <= bhi_nxt;
      avg_r      <= avg_nxt;
      flags_r    <= flags_nxt;
      done_r     <= done_nxt;
    end
  end

  // averaging divider
  uer_div #(
    .NW  (SUM_W),
    .DVW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (vcount_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.trigger_level    <= (phase_r == PH_TRIG);
      out_r.busy_res         <= (phase_r != PH_IDLE);
      out_r.done_res         <= done_r;
      out_r.average_valid    <= flags_r[0];
      out_r.average_distance <= avg_r;
      out_r.valid_readings   <= vcount_r;
      out_r.in_range         <= flags_r[1];
    end
  end

  assign out_data      = out_r;
  assign stat.need_fin = need_fin;
  assign stat.gap_end  = gap_end;
  assign stat.div_done = div_done;

  // checks
  a_vcount_le_readings: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= readings_r)
    else $error("valid count exceeds readings taken");

  a_trig_timer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TRIG) |-> (timer_r != '0))
    else $error("trigger phase with zero timer");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (phase_r == PH_IDLE))
    else $error("measurement done while not idle");

endmodule

>>> sv/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Ranger sequencer: takes one tick item, steps the datapath through the
// multiply/check or divide/average cycles it needs, and hands the result out.
// ----------------------------------------------------------------------------
module uer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  uer_pkg::dp_stat_t stat,
  output uer_pkg::dp_cmd_t  cmd
);
  import uer_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_STEP = 6'b000010,
    S_FIN  = 6'b000100,
    S_DIV  = 6'b001000,
    S_AVG  = 6'b010000,
    S_OUT  = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // sequencing
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (stat.need_fin) begin
          state_nxt = S_FIN;
        end else if (stat.gap_end) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        cmd.avg   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result presented without output state");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped before transfer");

endmodule

>>> sv/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Pulse-echo ranging with averaging; one input transfer per microsecond tick,
// one result transfer per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one tick and yields exactly one result transfer. A
// tick normally passes through accept, phase step and output register; the
// tick on which the echo falls adds a finish step, since the echo width is
// multiplied into a distance in a register before the limit check. The tick
// that ends a measurement also waits for the average, formed by a 22-step
// serial divider, one quotient bit per cycle. Input is
// taken only while the sequencer is idle; a result waiting in the output
// register does not block the next tick's work until it must be written.
// Configuration writes take effect at once and are meant for idle periods.
module ultrasonic_echo_ranger #(
  parameter int TIMER_BITS = uer_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  uer_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output uer_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [uer_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [uer_pkg::CFG_DW-1:0] cfg_wdata
);
  import uer_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  uer_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb
// Self-checking bench for the echo ranger. A sensor stand-in shapes the echo
// from the predicted measurement phase. A scoreboard predicts the report for
// every accepted tick and compares each returned report field by field, under
// random idling on both channels, a long output hold-off and several register
// settings.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int SETTLE_CYCLES = 40;   // covers the averaging tick
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_TICKS  = 500;

  // Predicts one report per tick and matches returned reports in order
  class range_scoreboard;
    logic [TRIG_W-1:0] trig_len;
    logic [LIM_W-1:0]  echo_tmo, gap_len;
    logic [CNT_W-1:0]  samples;
    logic [DIST_W-1:0] dist_min, dist_max;
    phase_t            ph;
    logic [LIM_W-1:0]  timer, width;
    logic [CNT_W-1:0]  taken, nvalid;
    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] bound_lo, bound_hi, avg;
    logic              avg_ok, avg_in;
    out_item_t         expected_reports[$];
    int                errors;

    function new();
      trig_len = TRIGGER_RST;
      echo_tmo = TIMEOUT_RST;
      gap_len  = GAP_RST;
      samples  = SAMPLES_RST;
      dist_min = MIN_RST;
      dist_max = MAX_RST;
      ph       = PH_IDLE;
      timer    = '0;
      width    = '0;
      taken    = '0;
      nvalid   = '0;
      sum      = '0;
      bound_lo = '0;
      bound_hi = '0;
      avg      = '0;
      avg_ok   = 1'b0;
      avg_in   = 1'b0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DW-1:0] v);
      case (r)
        REG_TRIGGER: trig_len = v[TRIG_W-1:0];
        REG_TIMEOUT: echo_tmo = v[LIM_W-1:0];
        REG_GAP:     gap_len  = v[LIM_W-1:0];
        REG_SAMPLES: samples  = v[CNT_W-1:0];
        REG_MIN:     dist_min = v[DIST_W-1:0];
        REG_MAX:     dist_max = v[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    // End of one reading: score the width, then start the gap
    function void close_reading(bit ok);
      logic [31:0] d;
      d = (32'(width) * DIST_MULT) >> DIST_SHIFT;
      if (ok && d != 0 && d >= dist_min && d <= dist_max) begin
        nvalid++;
        sum = sum + d[SUM_W-1:0];
      end
      taken++;
      ph    = PH_GAP;
      timer = '0;
    endfunction

    function void note_tick(in_item_t it);
      out_item_t        report;
      logic [CNT_W-1:0] wanted;
      bit               done;
      done   = 1'b0;
      wanted = (samples == 0) ? CNT_W'(1) : samples;
      if (wanted > MAX_SAMPLES) wanted = CNT_W'(MAX_SAMPLES);
      case (ph)
        PH_TRIG: begin
          if (timer >= trig_len) begin
            ph    = PH_RISE;
            timer = '0;
          end else begin
            timer++;
          end
        end
        PH_RISE: begin
          if (it.echo_level) begin
            ph    = PH_MEAS;
            width = '0;
          end else if (timer >= echo_tmo) begin
            close_reading(1'b0);
          end else begin
            timer++;
          end
        end
        PH_MEAS: begin
          if (!it.echo_level) close_reading(1'b1);
          else if (width >= echo_tmo) close_reading(1'b0);
          else width++;
        end
        PH_GAP: begin
          if (timer != '1) timer++;
          if (timer >= gap_len) begin
            if (taken >= wanted) begin
              // last gap over: average the valid readings
              avg    = '0;
              avg_ok = 1'b0;
              avg_in = 1'b0;
              if (nvalid != 0) begin
                avg    = DIST_W'(sum / nvalid);
                avg_ok = 1'b1;
                avg_in = (avg >= bound_lo && avg <= bound_hi);
              end
              ph    = PH_IDLE;
              timer = '0;
              done  = 1'b1;
            end else begin
              ph    = PH_TRIG;
              timer = LIM_W'(1);
            end
          end
        end
        default: begin
          ph = PH_IDLE;
          if (it.start_req) begin
            bound_lo = it.range_low;
            bound_hi = it.range_high;
            taken    = '0;
            nvalid   = '0;
            sum      = '0;
            width    = '0;
            ph       = PH_TRIG;
            timer    = LIM_W'(1);
          end
        end
      endcase
      report.trigger_level    = (ph == PH_TRIG);
      report.busy_res         = (ph != PH_IDLE);
      report.done_res         = done;
      report.average_valid    = avg_ok;
      report.average_distance = avg;
      report.valid_readings   = nvalid;
      report.in_range         = avg_in;
      expected_reports = {expected_reports, report};
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t unexpected report: expected none, actual %h", $time, got);
        return;
      end
      want = expected_reports.pop_front();
      compare("trigger_level", 32'(want.trigger_level), 32'(got.trigger_level));
      compare("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      compare("done_res", 32'(want.done_res), 32'(got.done_res));
      compare("average_valid", 32'(want.average_valid), 32'(got.average_valid));
      compare("average_distance", 32'(want.average_distance),
              32'(got.average_distance));
      compare("valid_readings", 32'(want.valid_readings), 32'(got.valid_readings));
      compare("in_range", 32'(want.in_range), 32'(got.in_range));
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_AW-1:0]    cfg_addr  = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;

  range_scoreboard sb;

  // Sensor stand-in and traffic knobs
  bit     quiet      = 1'b0;
  bit     hold_req   = 1'b0;
  int     noise_pct  = 0;
  int     rise_max   = 4;
  int     width_max  = 4;
  int     rise_q[$];
  int     width_q[$];
  int     rise_left  = 0;
  int     width_left = 0;
  phase_t prev_ph    = PH_IDLE;
  bit     tick_idle, tick_started;
  int     n_ticks    = 0;

  ultrasonic_echo_ranger u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_report(out_data);
      if (in_valid && in_ready) sb.note_tick(in_data);
    end
  end

  // Result side: random stalls, quiet stretches, one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Next tick from the predicted phase: echo rises after a planned delay
  // and stays high for a planned width
  function automatic in_item_t make_tick(bit want_start, logic [DIST_W-1:0] lo,
                                         logic [DIST_W-1:0] hi);
    in_item_t it;
    bit       echo;
    it.range_low  = DIST_W'($urandom);
    it.range_high = DIST_W'($urandom);
    it.start_req  = 1'b0;
    tick_idle     = (sb.ph == PH_IDLE);
    tick_started  = 1'b0;
    if (sb.ph == PH_TRIG && prev_ph != PH_TRIG) begin
      if (rise_q.size() != 0) rise_left = rise_q.pop_front();
      else rise_left = $urandom_range(0, rise_max);
      if (width_q.size() != 0) width_left = width_q.pop_front();
      else width_left = $urandom_range(0, width_max);
    end
    prev_ph = sb.ph;
    if (tick_idle) begin
      if (want_start) begin
        it.start_req  = 1'b1;
        it.range_low  = lo;
        it.range_high = hi;
        tick_started  = 1'b1;
      end
    end else begin
      it.start_req = ($urandom_range(0, 9) == 0);  // ignored while busy
    end
    case (sb.ph)
      PH_RISE: begin
        echo = (rise_left == 0);
        if (rise_left > 0) rise_left--;
      end
      PH_MEAS: begin
        echo = (width_left != 0);
        if (width_left > 0) width_left--;
      end
      default: echo = 1'b0;
    endcase
    if ($urandom_range(0, 99) < noise_pct) echo = !echo;
    it.echo_level = echo;
    return it;
  endfunction

  task automatic send_tick(bit want_start, logic [DIST_W-1:0] lo = '0,
                           logic [DIST_W-1:0] hi = '0);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= make_tick(want_start, lo, hi);
    do @(posedge clk); while (!in_ready);
    n_ticks++;
  endtask

  task automatic run_idle(int n);
    repeat (n) send_tick(1'b0);
  endtask

  // Start once idle, then tick until the measurement is over
  task automatic run_measurement(logic [DIST_W-1:0] lo, logic [DIST_W-1:0] hi);
    do send_tick(1'b1, lo, hi); while (!tick_started);
    do send_tick(1'b0); while (!tick_idle);
  endtask

  task automatic random_measurement();
    logic [DIST_W-1:0] lo, hi;
    case ($urandom_range(0, 2))
      0: begin
        lo = DIST_W'($urandom);
        hi = DIST_W'($urandom);
      end
      1: begin
        lo = '0;
        hi = '1;
      end
      default: begin
        lo = DIST_W'($urandom_range(0, 100));
        hi = lo + DIST_W'($urandom_range(0, 60));
      end
    endcase
    run_measurement(lo, hi);
  endtask

  // Stop offering, wait for every report, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int unsigned v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= CFG_DW'(v);
    sb.set_reg(r, CFG_DW'(v));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(int unsigned trig, int unsigned tmo, int unsigned gap,
                              int unsigned n, int unsigned dmin, int unsigned dmax);
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_GAP, gap);
    write_reg(REG_SAMPLES, n);
    write_reg(REG_MIN, dmin);
    write_reg(REG_MAX, dmax);
  endtask

  // Short timings so many measurements fit; timeouts and limits get hit
  task automatic random_config();
    int unsigned trig, tmo, gap, n, dmin, dmax, pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) n = 0;
    else if (pick < 20) n = $urandom_range(5, 15);
    else n = $urandom_range(1, 4);
    if ($urandom_range(0, 19) == 0) begin
      trig = 255;
      n    = 1;
    end else begin
      trig = $urandom_range(0, 6);
    end
    tmo  = $urandom_range(0, 30);
    gap  = $urandom_range(0, 5);
    dmin = $urandom_range(0, 40);
    if ($urandom_range(0, 4) == 0) dmax = $urandom_range(0, dmin);
    else dmax = $urandom_range(dmin, 140);
    apply_config(trig, tmo, gap, n, dmin, dmax);
    rise_max  = tmo + 4;
    width_max = tmo + 4;
    noise_pct = ($urandom_range(0, 2) == 0) ? 3 : 0;
  endtask

  initial begin
    int base;
    int seg;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: all report fields stay zero without a start
    run_idle(3);
    settle();

    // Zero trigger, timeout, gap and count: rise timeout, then width timeout
    apply_config(0, 0, 0, 0, 0, 262143);
    rise_q = {rise_q, 3};
    width_q = {width_q, 0};
    run_measurement('0, '0);
    rise_q = {rise_q, 0};
    width_q = {width_q, 2};
    run_measurement('1, '1);
    settle();

    // Zero-distance, valid and timed-out readings; average on both bounds
    apply_config(1, 6, 1, 3, 1, 30);
    rise_q = '{0, 0, 0};
    width_q = '{0, 2, 9};
    run_measurement(DIST_W'(8), DIST_W'(8));
    settle();

    // Top register values with one long echo, no idling on either side
    apply_config(255, 131071, 0, 1, 0, 262143);
    rise_q = {rise_q, 20};
    width_q = {width_q, 200};
    quiet = 1'b1;
    run_measurement('0, '1);
    quiet = 1'b0;
    settle();

    // Longest gap, largest count, minimum above maximum: idle ticks only
    apply_config(1, 1, 131071, 15, 262143, 0);
    run_idle(20);

    // Random settings and measurements
    base = n_ticks;
    seg  = 0;
    while (n_ticks - base < RANDOM_TICKS) begin
      settle();
      random_config();
      quiet = (seg >= 2 && seg <= 4);
      if (seg == 0) hold_req = 1'b1;
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 2) == 0) run_idle($urandom_range(1, 3));
        random_measurement();
      end
      seg++;
    end
    quiet = 1'b0;
    settle();

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
